>>> src/uwi_pkg.sv
// shared constants, codes and controller/datapath interface types for the word indexer
package uwi_pkg;

    // storage sizes
    localparam int STORE_DEPTH = 2048;
    localparam int TABLE_DEPTH = 512;
    localparam int WORD_LIMIT  = 50;

    // derived widths
    localparam int SA_W  = $clog2(STORE_DEPTH);
    localparam int SC_W  = SA_W + 1;
    localparam int TA_W  = $clog2(TABLE_DEPTH);
    localparam int TC_W  = TA_W + 1;
    localparam int LEN_W = 6;
    localparam int CNT_W = 11;
    localparam int ENT_W = SA_W + LEN_W + CNT_W;

    // record kinds
    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LONG  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    // outcome of a word lookup
    localparam logic [1:0] RES_MATCH = 2'd0;
    localparam logic [1:0] RES_NEW   = 2'd1;
    localparam logic [1:0] RES_LONG  = 2'd2;
    localparam logic [1:0] RES_FULL  = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       start_scan;
        logic       next_entry;
        logic       load_entry;
        logic       next_byte;
        logic       set_res;
        logic [1:0] res;
        logic       emit_word;
        logic       emit_total;
    } uwi_cmd_t;

    typedef struct packed {
        logic do_close;
        logic is_last;
        logic too_long;
        logic scan_done;
        logic len_eq;
        logic bytes_done;
        logic byte_eq;
        logic table_full;
        logic out_free;
    } uwi_status_t;

endpackage

>>> src/uwi_ram.sv
// generic single write port ram with registered read
module uwi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/uwi_ctrl.sv
// controller state machine sequencing byte intake, table scan and record output
module uwi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uwi_pkg::uwi_status_t sts,
    output uwi_pkg::uwi_cmd_t    cmd
);
    import uwi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_TCMP  = 3'd3;
    localparam logic [2:0] S_BYTE  = 3'd4;
    localparam logic [2:0] S_BCMP  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_TOTAL = 3'd7;

    logic [2:0] state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (sts.do_close && sts.too_long) begin
                    cmd.set_res = 1'b1;
                    cmd.res     = RES_LONG;
                    state_next  = S_EMIT;
                end else if (sts.do_close) begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_SCAN;
                end else if (sts.is_last) begin
                    state_next = S_TOTAL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    cmd.set_res = 1'b1;
                    cmd.res     = sts.table_full ? RES_FULL : RES_NEW;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_TCMP;
                end
            end
            S_TCMP: begin
                if (sts.len_eq) begin
                    cmd.load_entry = 1'b1;
                    state_next     = S_BYTE;
                end else begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_BYTE: begin
                if (sts.bytes_done) begin
                    cmd.set_res = 1'b1;
                    cmd.res     = RES_MATCH;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_BCMP;
                end
            end
            S_BCMP: begin
                if (sts.byte_eq) begin
                    cmd.next_byte = 1'b1;
                    state_next    = S_BYTE;
                end else begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_word = 1'b1;
                    state_next    = sts.is_last ? S_TOTAL : S_IDLE;
                end
            end
            S_TOTAL: begin
                if (sts.out_free) begin
                    cmd.emit_total = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> src/uwi_dp.sv
// datapath: byte store, word table, counters, comparators and output register
module uwi_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uwi_pkg::uwi_cmd_t    cmd,
    output uwi_pkg::uwi_status_t sts,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_end_of_text,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_record_kind,
    output logic [8:0]           m_entry_slot,
    output logic                 m_is_new_word,
    output logic [10:0]          m_word_offset,
    output logic [5:0]           m_word_length,
    output logic [10:0]          m_word_count,
    output logic [9:0]           m_unique_total,
    output logic [10:0]          m_words_total,
    output logic [11:0]          m_bytes_total,
    output logic [1:0]           m_status,
    output logic                 m_last_result
);
    import uwi_pkg::*;

    // running state
    logic [SC_W-1:0]  stored_reg, stored_next;
    logic [TC_W-1:0]  unique_reg, unique_next;
    logic [CNT_W-1:0] words_reg, words_next;
    logic [SA_W-1:0]  cur_start_reg, cur_start_next;
    logic             inside_reg, inside_next;
    logic             dropped_reg, dropped_next;

    // word being closed
    logic             close_reg, close_next;
    logic             last_reg, last_next;
    logic [SA_W-1:0]  w_start_reg, w_start_next;
    logic [SC_W-1:0]  w_len_reg, w_len_next;

    // scan state
    logic [TC_W-1:0]  idx_reg;
    logic [LEN_W-1:0] k_reg;
    logic [SA_W-1:0]  ent_off_reg;
    logic [CNT_W-1:0] ent_cnt_reg;
    logic [1:0]       res_reg;

    // ram signals
    logic             st_we;
    logic [SA_W-1:0]  st_waddr;
    logic [SA_W-1:0]  st_raddr_a, st_raddr_b;
    logic [7:0]       st_rdata_a, st_rdata_b;
    logic             tb_we;
    logic [TA_W-1:0]  tb_waddr;
    logic [ENT_W-1:0] tb_wdata, tb_rdata;
    logic [SA_W-1:0]  tb_off;
    logic [LEN_W-1:0] tb_len;
    logic [CNT_W-1:0] tb_cnt;

    logic             is_ws, not_full;
    logic [LEN_W-1:0] w_len6;

    // output register
    logic             m_valid_reg;
    logic             kind_reg, new_reg, olast_reg;
    logic [8:0]       slot_reg;
    logic [10:0]      off_reg, cnt_reg, wtot_reg;
    logic [5:0]       len_reg;
    logic [9:0]       utot_reg;
    logic [11:0]      btot_reg;
    logic [1:0]       stat_reg;

    assign is_ws    = (s_text_byte == 8'd32) || (s_text_byte >= 8'd9 && s_text_byte <= 8'd13);
    assign not_full = (stored_reg < SC_W'(STORE_DEPTH));
    assign w_len6   = w_len_reg[LEN_W-1:0];
    assign {tb_off, tb_len, tb_cnt} = tb_rdata;

    // byte intake and word boundaries
    always_comb begin
        logic [SA_W-1:0] st_a;
        logic            in_a;
        logic [SC_W-1:0] end_a;
        stored_next    = stored_reg;
        cur_start_next = cur_start_reg;
        inside_next    = inside_reg;
        dropped_next   = dropped_reg;
        close_next     = close_reg;
        last_next      = last_reg;
        w_start_next   = w_start_reg;
        w_len_next     = w_len_reg;
        st_we          = 1'b0;
        st_a           = cur_start_reg;
        in_a           = inside_reg;
        end_a          = stored_reg;
        if (cmd.accept) begin
            close_next = 1'b0;
            last_next  = s_end_of_text;
            if (not_full) begin
                st_we       = 1'b1;
                stored_next = stored_reg + 1'b1;
                if (is_ws) begin
                    if (inside_reg) begin
                        close_next   = 1'b1;
                        w_start_next = cur_start_reg;
                        w_len_next   = stored_reg - SC_W'(cur_start_reg);
                        in_a         = 1'b0;
                    end
                end else if (!inside_reg) begin
                    st_a = stored_reg[SA_W-1:0];
                    in_a = 1'b1;
                end
                end_a = stored_reg + 1'b1;
            end else begin
                dropped_next = 1'b1;
            end
            if (s_end_of_text && in_a) begin
                close_next   = 1'b1;
                w_start_next = st_a;
                w_len_next   = end_a - SC_W'(st_a);
                in_a         = 1'b0;
            end
            cur_start_next = st_a;
            inside_next    = in_a;
        end
        if (cmd.emit_total) begin
            stored_next    = '0;
            cur_start_next = '0;
            inside_next    = 1'b0;
            dropped_next   = 1'b0;
        end
    end

    assign st_waddr = stored_reg[SA_W-1:0];

    // counters and table write on word emission, counters cleared on totals
    always_comb begin
        unique_next = unique_reg;
        words_next  = words_reg;
        tb_we       = 1'b0;
        tb_waddr    = idx_reg[TA_W-1:0];
        tb_wdata    = {ent_off_reg, w_len6, ent_cnt_reg + 1'b1};
        if (cmd.emit_word) begin
            unique case (res_reg)
                RES_MATCH: begin
                    tb_we      = 1'b1;
                    words_next = words_reg + 1'b1;
                end
                RES_NEW: begin
                    tb_we       = 1'b1;
                    tb_waddr    = unique_reg[TA_W-1:0];
                    tb_wdata    = {w_start_reg, w_len6, CNT_W'(1)};
                    unique_next = unique_reg + 1'b1;
                    words_next  = words_reg + 1'b1;
                end
                default: ;
            endcase
        end
        if (cmd.emit_total) begin
            unique_next = '0;
            words_next  = '0;
        end
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg    <= '0;
            unique_reg    <= '0;
            words_reg     <= '0;
            cur_start_reg <= '0;
            inside_reg    <= 1'b0;
            dropped_reg   <= 1'b0;
            close_reg     <= 1'b0;
            last_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            stored_reg    <= stored_next;
            unique_reg    <= unique_next;
            words_reg     <= words_next;
            cur_start_reg <= cur_start_next;
            inside_reg    <= inside_next;
            dropped_reg   <= dropped_next;
            close_reg     <= close_next;
            last_reg      <= last_next;
            if (cmd.emit_word || cmd.emit_total) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // word and scan payload registers
    always_ff @(posedge aclk) begin
        w_start_reg <= w_start_next;
        w_len_reg   <= w_len_next;
        if (cmd.start_scan) begin
            idx_reg <= '0;
        end else if (cmd.next_entry) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.load_entry) begin
            ent_off_reg <= tb_off;
            ent_cnt_reg <= tb_cnt;
            k_reg       <= '0;
        end else if (cmd.next_byte) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.set_res) begin
            res_reg <= cmd.res;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_word) begin
            kind_reg  <= KIND_WORD;
            olast_reg <= !last_reg;
            utot_reg  <= 10'(unique_next);
            wtot_reg  <= 11'(words_next);
            // bytes stored up to the word's end, before any closing blank
            btot_reg  <= 12'(SC_W'(w_start_reg) + w_len_reg);
            unique case (res_reg)
                RES_MATCH: begin
                    slot_reg <= 9'(idx_reg);
                    new_reg  <= 1'b0;
                    off_reg  <= 11'(ent_off_reg);
                    len_reg  <= w_len6;
                    cnt_reg  <= 11'(ent_cnt_reg + 1'b1);
                    stat_reg <= ST_OK;
                end
                RES_NEW: begin
                    slot_reg <= 9'(unique_reg);
                    new_reg  <= 1'b1;
                    off_reg  <= 11'(w_start_reg);
                    len_reg  <= w_len6;
                    cnt_reg  <= 11'd1;
                    stat_reg <= ST_OK;
                end
                RES_LONG: begin
                    slot_reg <= '0;
                    new_reg  <= 1'b0;
                    off_reg  <= 11'(w_start_reg);
                    len_reg  <= '0;
                    cnt_reg  <= '0;
                    stat_reg <= ST_LONG;
                end
                default: begin
                    slot_reg <= '0;
                    new_reg  <= 1'b0;
                    off_reg  <= 11'(w_start_reg);
                    len_reg  <= w_len6;
                    cnt_reg  <= '0;
                    stat_reg <= ST_FULL;
                end
            endcase
        end else if (cmd.emit_total) begin
            kind_reg  <= KIND_TOTAL;
            olast_reg <= 1'b1;
            slot_reg  <= '0;
            new_reg   <= 1'b0;
            off_reg   <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            utot_reg  <= 10'(unique_reg);
            wtot_reg  <= 11'(words_reg);
            btot_reg  <= 12'(stored_reg);
            stat_reg  <= dropped_reg ? ST_DROP : ST_OK;
        end
    end

    // store read addresses: table word byte and closing word byte
    assign st_raddr_a = ent_off_reg + SA_W'(k_reg);
    assign st_raddr_b = w_start_reg + SA_W'(k_reg);

    // byte store, mirrored for two reads a cycle
    uwi_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_a (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (s_text_byte),
        .raddr (st_raddr_a),
        .rdata (st_rdata_a)
    );

    uwi_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_b (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (s_text_byte),
        .raddr (st_raddr_b),
        .rdata (st_rdata_b)
    );

    // unique word table
    uwi_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (tb_wdata),
        .raddr (idx_reg[TA_W-1:0]),
        .rdata (tb_rdata)
    );

    // status to the controller
    always_comb begin
        sts.do_close   = close_reg;
        sts.is_last    = last_reg;
        sts.too_long   = (w_len_reg >= SC_W'(WORD_LIMIT));
        sts.scan_done  = (idx_reg == unique_reg);
        sts.len_eq     = (tb_len == w_len6);
        sts.bytes_done = (k_reg == w_len6);
        sts.byte_eq    = (st_rdata_a == st_rdata_b);
        sts.table_full = (unique_reg == TC_W'(TABLE_DEPTH));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_record_kind  = kind_reg;
    assign m_entry_slot   = slot_reg;
    assign m_is_new_word  = new_reg;
    assign m_word_offset  = off_reg;
    assign m_word_length  = len_reg;
    assign m_word_count   = cnt_reg;
    assign m_unique_total = utot_reg;
    assign m_words_total  = wtot_reg;
    assign m_bytes_total  = btot_reg;
    assign m_status       = stat_reg;
    assign m_last_result  = olast_reg;

endmodule

>>> src/unique_word_indexer.sv
// top level of the unique word indexer
// flow: a byte that closes no word passes the idle and check states; a closing word
// then scans the table entry by entry, comparing bytes on a length match, before its emit.
// an end of text adds the totals beat; an output stall holds the pending beat.
// throughput: one beat at a time; the serial table scan through one ram read port sets it.
// reset: synchronous active low, clears counters, controller and output valid;
// stores are not cleared, entries past the fill counts are never read.
module unique_word_indexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_record_kind,
    output logic [8:0]  m_entry_slot,
    output logic        m_is_new_word,
    output logic [10:0] m_word_offset,
    output logic [5:0]  m_word_length,
    output logic [10:0] m_word_count,
    output logic [9:0]  m_unique_total,
    output logic [10:0] m_words_total,
    output logic [11:0] m_bytes_total,
    output logic [1:0]  m_status,
    output logic        m_last_result
);
    import uwi_pkg::*;

    uwi_cmd_t    cmd;
    uwi_status_t sts;

    // sequencer
    uwi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and compare
    uwi_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_text_byte    (s_text_byte),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_record_kind  (m_record_kind),
        .m_entry_slot   (m_entry_slot),
        .m_is_new_word  (m_is_new_word),
        .m_word_offset  (m_word_offset),
        .m_word_length  (m_word_length),
        .m_word_count   (m_word_count),
        .m_unique_total (m_unique_total),
        .m_words_total  (m_words_total),
        .m_bytes_total  (m_bytes_total),
        .m_status       (m_status),
        .m_last_result  (m_last_result)
    );

endmodule

>>> dv/testbench.sv
// self-checking testbench for the unique word indexer: byte texts, word records and totals
`timescale 1ns / 100ps

module testbench;
    import uwi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_BYTES   = 850;

    // one output beat of the indexer
    typedef struct packed {
        logic        kind;
        logic [8:0]  slot;
        logic        fresh;
        logic [10:0] offset;
        logic [5:0]  length;
        logic [10:0] count;
        logic [9:0]  uniques;
        logic [10:0] words;
        logic [11:0] bytes;
        logic [1:0]  status;
        logic        last;
    } word_record_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = 8'd0;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_record_kind;
    logic [8:0]  m_entry_slot;
    logic        m_is_new_word;
    logic [10:0] m_word_offset;
    logic [5:0]  m_word_length;
    logic [10:0] m_word_count;
    logic [9:0]  m_unique_total;
    logic [10:0] m_words_total;
    logic [11:0] m_bytes_total;
    logic [1:0]  m_status;
    logic        m_last_result;

    unique_word_indexer dut (.*);

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow copy of the indexer state
    logic [7:0]  text_mem [STORE_DEPTH];
    logic [10:0] entry_off [TABLE_DEPTH];
    logic [5:0]  entry_len [TABLE_DEPTH];
    logic [10:0] entry_cnt [TABLE_DEPTH];
    int          n_stored, n_unique, n_words, word_start;
    bit          in_word, any_dropped;

    word_record_t pending_records[$];
    int errors = 0;
    int bytes_sent = 0;
    int tx_max_gap = 0;
    int rx_max_stall = 0;
    int hold_cycles = 0;
    bit done = 1'b0;

    const logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    function automatic bit is_blank(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void queue_record(logic kind, int slot, logic fresh, int offset,
                                         int length, int count, logic [1:0] status);
        word_record_t r;
        r.kind = kind; r.slot = 9'(slot); r.fresh = fresh; r.offset = 11'(offset);
        r.length = 6'(length); r.count = 11'(count); r.uniques = 10'(n_unique);
        r.words = 11'(n_words); r.bytes = 12'(n_stored); r.status = status; r.last = 1'b0;
        pending_records.push_back(r);
    endfunction

    // look a finished word up in the table and record the outcome
    function automatic void finish_word();
        int len;
        bit hit;
        len = n_stored - word_start;
        in_word = 1'b0;
        if (len >= WORD_LIMIT) begin
            queue_record(KIND_WORD, 0, 1'b0, word_start, 0, 0, ST_LONG);
            return;
        end
        for (int i = 0; i < n_unique; i++) begin
            if (entry_len[i] == len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (text_mem[entry_off[i] + k] != text_mem[word_start + k]) hit = 1'b0;
                if (hit) begin
                    entry_cnt[i]++;
                    n_words++;
                    queue_record(KIND_WORD, i, 1'b0, entry_off[i], len, entry_cnt[i], ST_OK);
                    return;
                end
            end
        end
        if (n_unique >= TABLE_DEPTH) begin
            queue_record(KIND_WORD, 0, 1'b0, word_start, len, 0, ST_FULL);
            return;
        end
        entry_off[n_unique] = 11'(word_start);
        entry_len[n_unique] = 6'(len);
        entry_cnt[n_unique] = 11'd1;
        n_unique++;
        n_words++;
        queue_record(KIND_WORD, n_unique - 1, 1'b1, word_start, len, 1, ST_OK);
    endfunction

    function automatic void clear_text();
        n_stored = 0; n_unique = 0; n_words = 0; word_start = 0;
        in_word = 1'b0; any_dropped = 1'b0;
    endfunction

    // expected records for one accepted byte
    function automatic void index_byte(logic [7:0] b, logic eot);
        int before_n;
        before_n = pending_records.size();
        if (n_stored < STORE_DEPTH) begin
            if (is_blank(b)) begin
                if (in_word) finish_word();
            end else if (!in_word) begin
                word_start = n_stored;
                in_word = 1'b1;
            end
            text_mem[n_stored] = b;
            n_stored++;
        end else begin
            any_dropped = 1'b1;
        end
        if (eot) begin
            if (in_word) finish_word();
            queue_record(KIND_TOTAL, 0, 1'b0, 0, 0, 0, any_dropped ? ST_DROP : ST_OK);
            clear_text();
        end
        if (pending_records.size() > before_n)
            pending_records[pending_records.size() - 1].last = 1'b1;
    endfunction

    // send one beat and predict at acceptance
    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        index_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        go_idle();
        while (pending_records.size() > 0) @(posedge aclk);
    endtask

    task automatic send_word(int len, int alpha);
        for (int i = 0; i < len; i++)
            send_byte(8'(8'h61 + $urandom_range(0, alpha - 1)), 1'b0);
    endtask

    task automatic send_blank(logic eot);
        send_byte(blanks[$urandom_range(0, 5)], eot);
    endtask

    // extremes of the byte, every blank kind, repeats, long words, end of text forms
    task automatic test_directed();
        tx_max_gap = 0; rx_max_stall = 0;
        send_byte(8'h20, 1'b1);             // empty text: totals only
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        for (int i = 0; i < 6; i++) send_byte(blanks[i], 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);             // repeat of the first word
        send_byte(8'h09, 1'b0);
        send_byte(8'h08, 1'b0);             // next to the blank range
        send_byte(8'h0E, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h1F, 1'b1);             // end of text inside a word
        for (int i = 0; i < WORD_LIMIT - 1; i++) send_byte(8'h7A, 1'b0);
        send_byte(8'h20, 1'b0);             // longest word that is indexed
        for (int i = 0; i < WORD_LIMIT; i++) send_byte(8'h7A, 1'b0);
        send_byte(8'h0A, 1'b0);             // shortest word that is too long
        send_byte(8'h7A, 1'b0);
        send_byte(8'h0D, 1'b1);             // end of text on a blank
        wait_drained();
    endtask

    // random texts of words from small alphabets, with noise
    task automatic test_random_texts();
        int r;
        while (bytes_sent < RANDOM_BYTES) begin
            tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 19;
            rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 19;
            repeat ($urandom_range(3, 25)) begin
                r = $urandom_range(0, 19);
                if (r == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
                else if (r == 1) send_word($urandom_range(45, 55), 2);
                else send_word($urandom_range(1, 4), $urandom_range(2, 4));
                repeat ($urandom_range(1, 2)) send_blank(1'b0);
            end
            if ($urandom_range(0, 1)) send_word($urandom_range(1, 3), 3);
            if ($urandom_range(0, 1)) send_blank(1'b1);
            else send_byte(8'(8'h61 + $urandom_range(0, 2)), 1'b1);
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps going, then sender waits for all results
    task automatic test_backpressure();
        tx_max_gap = 0; rx_max_stall = 0;
        hold_cycles = 600;
        repeat (20) begin
            send_word($urandom_range(1, 3), 2);
            send_blank(1'b0);
        end
        send_blank(1'b1);
        wait_drained();
        tx_max_gap = 19; rx_max_stall = 19;
        repeat (10) begin
            send_word($urandom_range(1, 3), 3);
            send_blank(1'b0);
        end
        send_blank(1'b1);
        wait_drained();
    endtask

    // fill the table past its depth, then overflow the byte store
    task automatic test_full_text();
        tx_max_gap = 0; rx_max_stall = 0;
        for (int i = 0; i < TABLE_DEPTH + 18; i++) begin
            send_byte(8'(8'h41 + i / 58), 1'b0);
            send_byte(8'(8'h41 + i % 58), 1'b0);
            send_blank(1'b0);
        end
        for (int i = 0; i < 200; i++) begin
            int w;
            w = $urandom_range(0, TABLE_DEPTH + 17);
            send_byte(8'(8'h41 + w / 58), 1'b0);
            send_byte(8'(8'h41 + w % 58), 1'b0);
            send_blank(1'b0);
        end
        send_byte(8'h41, 1'b1);
        wait_drained();
    endtask

    // receiver ready with random stalls and the long hold
    always @(posedge aclk) begin : rx_ready
        int stall_left;
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready) begin
                stall_left = $urandom_range(0, rx_max_stall);
                if (stall_left > 0) m_ready <= 1'b0;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        word_record_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_record_kind, m_entry_slot, m_is_new_word, m_word_offset,
                    m_word_length, m_word_count, m_unique_total, m_words_total,
                    m_bytes_total, m_status, m_last_result};
            if (pending_records.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = pending_records.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin : watchdog
        int quiet;
        if ((s_valid && s_ready) || (m_valid && m_ready) || done) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        clear_text();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_texts();
        test_backpressure();
        test_full_text();
        done = 1'b1;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_records.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
